// ===== rtl/ahlp_pkg.sv =====
`timescale 1ns / 1ps

package ahlp_pkg;

   localparam int AddrWidthDefault = 32;

   // character codes
   localparam logic [7:0] CharStx    = 8'h02;
   localparam logic [7:0] CharEtx    = 8'h03;
   localparam logic [7:0] CharTab    = 8'h09;
   localparam logic [7:0] CharLf     = 8'h0A;
   localparam logic [7:0] CharVt     = 8'h0B;
   localparam logic [7:0] CharFf     = 8'h0C;
   localparam logic [7:0] CharCr     = 8'h0D;
   localparam logic [7:0] CharSpace  = 8'h20;
   localparam logic [7:0] CharDollar = 8'h24;
   localparam logic [7:0] CharPct    = 8'h25;
   localparam logic [7:0] CharQuote  = 8'h27;
   localparam logic [7:0] CharComma  = 8'h2C;
   localparam logic [7:0] CharDot    = 8'h2E;
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharNine   = 8'h39;
   localparam logic [7:0] CharUpA    = 8'h41;
   localparam logic [7:0] CharUpF    = 8'h46;
   localparam logic [7:0] CharUpS    = 8'h53;
   localparam logic [7:0] CharLowA   = 8'h61;
   localparam logic [7:0] CharLowF   = 8'h66;

   localparam logic [15:0] SumMask = 16'hFFFF;

   typedef enum logic [3:0] {
      PH_WAIT = 4'd0,
      PH_BODY = 4'd1,
      PH_HEX2 = 4'd2,
      PH_SEP  = 4'd3,
      PH_OPT  = 4'd4,
      PH_CMDL = 4'd5,
      PH_CMD1 = 4'd6,
      PH_CMDN = 4'd7,
      PH_PEND = 4'd8,
      PH_DONE = 4'd9,
      PH_DEAD = 4'd10
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_ILLEGAL   = 3'd1,
      ERR_BAD_HEX   = 3'd2,
      ERR_NO_SEP    = 3'd3,
      ERR_UNK_CMD   = 3'd4,
      ERR_CHECKSUM  = 3'd5,
      ERR_NO_DATA   = 3'd6,
      ERR_TRUNCATED = 3'd7
   } err_type;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_ADDR  = 2'd1,
      CMD_SUM   = 2'd2,
      CMD_OTHER = 2'd3
   } cmd_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] hex_val;
      logic       is_etx;
      logic       is_stx;
      logic       is_dollar;
      logic       is_body_ws;   // space, tab, CR, LF, FF
      logic       is_any_space; // body whitespace plus VT
      logic       is_opt_sep;   // quote, comma, percent, space
      logic       is_term;      // comma or dot
      cmd_type    letter;
   } char_class_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [31:0] addr;
      logic [7:0]  value;
      err_type     err;
   } result_type;

endpackage

// ===== rtl/ascii_hex_load_parser.sv =====
// A character taken on req_ is held in the input register; any result that it gives
// is held in the result register and shown on rsp_. One character per cycle while the
// result slot is empty or drains; the parse logic lies between those two registers.
// A character steps the parser only when the result slot is empty or drains that cycle.
// Reset (synchronous, active high) returns to waiting for STX with address, sum and
// seen flag cleared, and sets the checksum enable to 1.
`timescale 1ns / 1ps

module ascii_hex_load_parser
   import ahlp_pkg::*;
#(
   parameter int ADDR_WIDTH = AddrWidthDefault
)
(
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [7:0] char_in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,  // end_of_input
   // rsp_tdata: [31:0] byte_address, [39:32] byte_value, [42:40] error_code, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   // rsp_tuser: [1:0] kind
   output logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data    // check_sum_enable
);

   logic           in_valid_ff;
   logic [7:0]     in_char_ff;
   logic           in_eof_ff;
   logic           rsp_valid_ff;
   logic [47:0]    rsp_data_ff;
   logic [1:0]     rsp_user_ff;
   logic           check_en_ff;
   logic           advance;
   char_class_type cls;
   result_type     res;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         check_en_ff <= 1'b1;
      end else if (csr_valid) begin
         check_en_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_eof_ff  <= req_tlast;
      end
   end

   ahlp_char_class u_class (
      .char_in (in_char_ff),
      .cls     (cls)
   );

   ahlp_parse_core #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .eof      (in_eof_ff),
      .cls      (cls),
      .check_en (check_en_ff),
      .res      (res)
   );

   // result slot is free or being drained whenever the core steps
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= res.valid;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res.valid) begin
         rsp_data_ff <= {5'b0, res.err, res.value, res.addr};
         rsp_user_ff <= res.kind;
      end
   end

endmodule

// ===== rtl/ahlp_char_class.sv =====
`timescale 1ns / 1ps

module ahlp_char_class
   import ahlp_pkg::*;
(
   input  logic [7:0]     char_in,
   output char_class_type cls
);

   always_comb begin
      cls = '0;
      cls.letter = CMD_OTHER;
      if (char_in inside {[CharZero:CharNine]}) begin
         cls.is_hex  = 1'b1;
         cls.hex_val = 4'(char_in - CharZero);
      end else if (char_in inside {[CharLowA:CharLowF]}) begin
         cls.is_hex  = 1'b1;
         cls.hex_val = 4'(char_in - CharLowA + 8'd10);
      end else if (char_in inside {[CharUpA:CharUpF]}) begin
         cls.is_hex  = 1'b1;
         cls.hex_val = 4'(char_in - CharUpA + 8'd10);
      end
      cls.is_etx       = (char_in == CharEtx);
      cls.is_stx       = (char_in == CharStx);
      cls.is_dollar    = (char_in == CharDollar);
      cls.is_body_ws   = char_in inside {CharSpace, CharTab, CharCr, CharLf, CharFf};
      cls.is_any_space = char_in inside {CharSpace, CharTab, CharCr, CharLf, CharFf, CharVt};
      cls.is_opt_sep   = char_in inside {CharQuote, CharComma, CharPct, CharSpace};
      cls.is_term      = char_in inside {CharComma, CharDot};
      if (char_in == CharUpA) begin
         cls.letter = CMD_ADDR;
      end else if (char_in == CharUpS) begin
         cls.letter = CMD_SUM;
      end
   end

endmodule

// ===== rtl/ahlp_parse_core.sv =====
`timescale 1ns / 1ps

module ahlp_parse_core
   import ahlp_pkg::*;
#(
   parameter int ADDR_WIDTH = AddrWidthDefault
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic           eof,
   input  char_class_type cls,
   input  logic           check_en,
   output result_type     res
);

   localparam int ExtW = (ADDR_WIDTH > 32) ? ADDR_WIDTH : 32;

   phase_type             phase_ff, phase_in;
   logic [3:0]            nibble_ff, nibble_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic [ADDR_WIDTH-1:0] value_ff, value_in;
   cmd_type               letter_ff, letter_in;
   logic [15:0]           sum_ff, sum_in;
   logic                  seen_ff, seen_in;

   logic                  body_step, do_emit, do_finish, do_fail;
   err_type               fail_code;
   logic [ExtW-1:0]       addr_ext;

   assign addr_ext = ExtW'(addr_ff);

   always_comb begin
      phase_in  = phase_ff;
      nibble_in = nibble_ff;
      addr_in   = addr_ff;
      value_in  = value_ff;
      letter_in = letter_ff;
      sum_in    = sum_ff;
      seen_in   = seen_ff;
      body_step = 1'b0;
      do_emit   = 1'b0;
      do_finish = 1'b0;
      do_fail   = 1'b0;
      fail_code = ERR_NONE;
      res.valid = 1'b0;
      res.kind  = KIND_DATA;
      res.addr  = '0;
      res.value = '0;
      res.err   = ERR_NONE;

      case (phase_ff)
         PH_WAIT: begin
            if (eof) begin
               do_finish = 1'b1;
            end else if (cls.is_stx) begin
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            if (eof) begin
               do_finish = 1'b1;
            end else begin
               body_step = 1'b1;
            end
         end
         PH_HEX2: begin
            if (eof) begin
               do_fail = 1'b1; fail_code = ERR_TRUNCATED;
            end else if (!cls.is_hex) begin
               do_fail = 1'b1; fail_code = ERR_BAD_HEX;
            end else begin
               value_in = ADDR_WIDTH'({nibble_ff, cls.hex_val});
               phase_in = PH_SEP;
            end
         end
         PH_SEP: begin
            if (eof) begin
               phase_in = PH_PEND;
               do_emit  = 1'b1;
            end else if (!cls.is_any_space) begin
               do_fail = 1'b1; fail_code = ERR_NO_SEP;
            end else begin
               phase_in = PH_OPT;
               do_emit  = 1'b1;
            end
         end
         PH_OPT: begin
            if (eof) begin
               do_finish = 1'b1;
            end else if (cls.is_opt_sep) begin
               phase_in = PH_BODY;
            end else begin
               body_step = 1'b1;
            end
         end
         PH_CMDL: begin
            if (eof) begin
               do_fail = 1'b1; fail_code = ERR_TRUNCATED;
            end else begin
               letter_in = cls.letter;
               value_in  = '0;
               phase_in  = PH_CMD1;
            end
         end
         PH_CMD1, PH_CMDN: begin
            if (eof) begin
               do_fail = 1'b1; fail_code = ERR_TRUNCATED;
            end else if (phase_ff == PH_CMDN && cls.is_term) begin
               case (letter_ff)
                  CMD_ADDR: begin
                     addr_in  = value_ff;
                     phase_in = PH_BODY;
                  end
                  CMD_SUM: begin
                     if (check_en && ((sum_ff & SumMask) != value_ff[15:0])) begin
                        do_fail = 1'b1; fail_code = ERR_CHECKSUM;
                     end else begin
                        phase_in = PH_BODY;
                     end
                  end
                  default: begin
                     do_fail = 1'b1; fail_code = ERR_UNK_CMD;
                  end
               endcase
            end else if (!cls.is_hex) begin
               do_fail = 1'b1; fail_code = ERR_BAD_HEX;
            end else begin
               value_in = {value_ff[ADDR_WIDTH-5:0], cls.hex_val};
               phase_in = PH_CMDN;
            end
         end
         PH_PEND: begin
            do_finish = 1'b1;
         end
         default: ;
      endcase

      if (body_step) begin
         if (cls.is_hex) begin
            nibble_in = cls.hex_val;
            phase_in  = PH_HEX2;
         end else if (cls.is_etx) begin
            do_finish = 1'b1;
         end else if (cls.is_body_ws) begin
            phase_in = PH_BODY;
         end else if (cls.is_dollar) begin
            phase_in = PH_CMDL;
         end else begin
            do_fail = 1'b1; fail_code = ERR_ILLEGAL;
         end
      end

      if (do_emit) begin
         res.valid = 1'b1;
         res.kind  = KIND_DATA;
         res.addr  = addr_ext[31:0];
         res.value = value_ff[7:0];
         addr_in   = addr_ff + 1'b1;
         sum_in    = sum_ff + 16'(value_ff[7:0]);
         seen_in   = 1'b1;
      end

      if (do_finish) begin
         phase_in  = PH_DONE;
         res.valid = 1'b1;
         if (seen_ff) begin
            res.kind = KIND_END;
         end else begin
            res.kind = KIND_ERROR;
            res.err  = ERR_NO_DATA;
         end
      end

      if (do_fail) begin
         phase_in  = PH_DEAD;
         res.valid = 1'b1;
         res.kind  = KIND_ERROR;
         res.err   = fail_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         nibble_ff <= '0;
         addr_ff   <= '0;
         value_ff  <= '0;
         letter_ff <= CMD_NONE;
         sum_ff    <= '0;
         seen_ff   <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         nibble_ff <= nibble_in;
         addr_ff   <= addr_in;
         value_ff  <= value_in;
         letter_ff <= letter_in;
         sum_ff    <= sum_in;
         seen_ff   <= seen_in;
      end
   end

   // terminal phases swallow everything
   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      step && (phase_ff == PH_DONE || phase_ff == PH_DEAD) |-> !res.valid)
      else $error("result produced after end of load");

   a_data_sets_seen: assert property (@(posedge clock) disable iff (reset)
      step && res.valid && res.kind == KIND_DATA |=> seen_ff)
      else $error("data byte transfer did not mark seen_data");

   a_error_terminal: assert property (@(posedge clock) disable iff (reset)
      step && res.valid && res.kind == KIND_ERROR
      |=> phase_ff == PH_DEAD || phase_ff == PH_DONE)
      else $error("error did not stop the parser");

   a_pend_finishes: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_PEND |-> res.valid && res.kind != KIND_DATA)
      else $error("pending end produced no end result");

endmodule

// ===== bench/parse_result_monitor.sv =====
`timescale 1ns / 1ps

module parse_result_monitor
   import ahlp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_data,
   output int          mismatch_count,
   output int          pending_results
);

   typedef struct packed {
      kind_type    kind;
      logic [31:0] addr;
      logic [7:0]  value;
      err_type     err;
   } load_result_type;

   load_result_type expected_results[$];

   // shadow of the parser state
   phase_type   parse_phase;
   logic [3:0]  high_digit;
   logic [31:0] load_addr;
   logic [31:0] cmd_value;
   cmd_type     cmd_letter;
   logic [15:0] data_sum;
   logic        data_seen;
   logic        sum_check_on;

   function automatic int digit_of(input logic [7:0] c);
      if (c >= CharZero && c <= CharNine) return int'(c - CharZero);
      if (c >= CharLowA && c <= CharLowF) return int'(c - CharLowA) + 10;
      if (c >= CharUpA && c <= CharUpF) return int'(c - CharUpA) + 10;
      return -1;
   endfunction

   task automatic queue_result(input kind_type kind, input logic [31:0] addr,
                               input logic [7:0] value, input err_type err);
      load_result_type r;
      r.kind  = kind;
      r.addr  = addr;
      r.value = value;
      r.err   = err;
      expected_results.push_back(r);
   endtask

   task automatic abort_load(input err_type err);
      parse_phase = PH_DEAD;
      queue_result(KIND_ERROR, '0, '0, err);
   endtask

   task automatic close_load();
      parse_phase = PH_DONE;
      if (data_seen) queue_result(KIND_END, '0, '0, ERR_NONE);
      else queue_result(KIND_ERROR, '0, '0, ERR_NO_DATA);
   endtask

   // pending byte sits in the low bits of the command value
   task automatic emit_data();
      queue_result(KIND_DATA, load_addr, cmd_value[7:0], ERR_NONE);
      load_addr = load_addr + 32'd1;
      data_sum  = data_sum + {8'd0, cmd_value[7:0]};
      data_seen = 1'b1;
   endtask

   task automatic body_char(input logic [7:0] c);
      int d;
      d = digit_of(c);
      if (d >= 0) begin
         high_digit  = d[3:0];
         parse_phase = PH_HEX2;
      end else if (c == CharEtx) begin
         close_load();
      end else if (c == CharSpace || c == CharTab || c == CharCr || c == CharLf ||
                   c == CharFf) begin
         parse_phase = PH_BODY;
      end else if (c == CharDollar) begin
         parse_phase = PH_CMDL;
      end else begin
         abort_load(ERR_ILLEGAL);
      end
   endtask

   task automatic advance_parser(input logic [7:0] c, input logic eof);
      int d;
      d = digit_of(c);
      case (parse_phase)
         PH_WAIT: begin
            if (eof) close_load();
            else if (c == CharStx) parse_phase = PH_BODY;
         end
         PH_BODY: begin
            if (eof) close_load();
            else body_char(c);
         end
         PH_HEX2: begin
            if (eof) abort_load(ERR_TRUNCATED);
            else if (d < 0) abort_load(ERR_BAD_HEX);
            else begin
               cmd_value   = {24'd0, high_digit, d[3:0]};
               parse_phase = PH_SEP;
            end
         end
         PH_SEP: begin
            if (eof) begin
               parse_phase = PH_PEND;
               emit_data();
            end else if (c == CharSpace || c == CharTab || c == CharLf || c == CharVt ||
                         c == CharFf || c == CharCr) begin
               parse_phase = PH_OPT;
               emit_data();
            end else begin
               abort_load(ERR_NO_SEP);
            end
         end
         PH_OPT: begin
            if (eof) close_load();
            else if (c == CharQuote || c == CharComma || c == CharPct || c == CharSpace)
               parse_phase = PH_BODY;
            else body_char(c);
         end
         PH_CMDL: begin
            if (eof) abort_load(ERR_TRUNCATED);
            else begin
               cmd_letter  = (c == CharUpA) ? CMD_ADDR : (c == CharUpS) ? CMD_SUM : CMD_OTHER;
               cmd_value   = '0;
               parse_phase = PH_CMD1;
            end
         end
         PH_CMD1, PH_CMDN: begin
            if (eof) begin
               abort_load(ERR_TRUNCATED);
            end else if (parse_phase == PH_CMDN && (c == CharComma || c == CharDot)) begin
               if (cmd_letter == CMD_ADDR) begin
                  load_addr   = cmd_value;
                  parse_phase = PH_BODY;
               end else if (cmd_letter == CMD_SUM &&
                            (!sum_check_on || cmd_value[15:0] == data_sum)) begin
                  parse_phase = PH_BODY;
               end else if (cmd_letter == CMD_SUM) begin
                  abort_load(ERR_CHECKSUM);
               end else begin
                  abort_load(ERR_UNK_CMD);
               end
            end else if (d < 0) begin
               abort_load(ERR_BAD_HEX);
            end else begin
               cmd_value   = {cmd_value[27:0], d[3:0]};
               parse_phase = PH_CMDN;
            end
         end
         PH_PEND: close_load();
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      load_result_type got;
      load_result_type want;
      if (reset) begin
         parse_phase  = PH_WAIT;
         high_digit   = '0;
         load_addr    = '0;
         cmd_value    = '0;
         cmd_letter   = CMD_NONE;
         data_sum     = '0;
         data_seen    = 1'b0;
         sum_check_on = 1'b1;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) sum_check_on = csr_data;
         if (req_tvalid && req_tready) advance_parser(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got.kind  = kind_type'(rsp_tuser);
            got.addr  = rsp_tdata[31:0];
            got.value = rsp_tdata[39:32];
            got.err   = err_type'(rsp_tdata[42:40]);
            if (expected_results.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result: kind %0d addr %h value %h err %0d",
                           got.kind, got.addr, got.value, got.err);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.kind !== want.kind || got.addr !== want.addr ||
                   got.value !== want.value || got.err !== want.err) begin
                  if (mismatch_count < 10)
                     $display("result mismatch: expected kind %0d addr %h value %h err %0d, %s",
                              want.kind, want.addr, want.value, want.err,
                              $sformatf("got kind %0d addr %h value %h err %0d",
                                        got.kind, got.addr, got.value, got.err));
                  mismatch_count++;
               end
            end
         end
      end
      pending_results = expected_results.size();
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import ahlp_pkg::*;

   localparam int RunLimit   = 100000;
   localparam int HoldCycles = 200;
   localparam int PhaseItems = 190;
   localparam int OpeningItems = 31;
   localparam logic [7:0] NoChar = 8'h00;

   typedef enum int {
      END_ETX,
      END_EOF_BODY,
      END_EOF_AFTER_PAIR,
      END_EOF_IN_PAIR,
      END_EOF_AFTER_DOLLAR,
      END_EOF_IN_CMD,
      END_ILLEGAL,
      END_BAD_PAIR_HEX,
      END_BAD_CMD_HEX,
      END_NO_SEP,
      END_UNKNOWN_CMD,
      END_SUM_MISMATCH
   } load_end_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b0;
   logic        want_ready = 1'b0;
   logic        stall_hold = 1'b0;

   int          mismatch_count;
   int          pending_results;
   int          sent_items = 0;
   int          cycle_count = 0;
   logic [15:0] sent_sum = '0;
   logic        check_on = 1'b1;
   bit          send_quiet = 1'b0;
   bit          recv_quiet = 1'b0;

   assign rsp_tready = want_ready & ~stall_hold;

   ascii_hex_load_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   parse_result_monitor u_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
      if (v < 4'd10) return CharZero + 8'(v);
      return (lower ? CharLowA : CharUpA) + 8'(v - 4'd10);
   endfunction

   function automatic logic [7:0] pick_sep();
      case ($urandom_range(0, 5))
         0: return CharSpace;
         1: return CharTab;
         2: return CharLf;
         3: return CharVt;
         4: return CharFf;
         default: return CharCr;
      endcase
   endfunction

   function automatic logic [7:0] pick_opt();
      case ($urandom_range(0, 4))
         0: return NoChar;
         1: return CharQuote;
         2: return CharComma;
         3: return CharPct;
         default: return CharSpace;
      endcase
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 4))
         0: return CharSpace;
         1: return CharTab;
         2: return CharCr;
         3: return CharLf;
         default: return CharFf;
      endcase
   endfunction

   function automatic logic [7:0] pick_term();
      return $urandom_range(0, 1) ? CharComma : CharDot;
   endfunction

   // one character transfer, with a random gap in front
   task automatic send_char(input logic [7:0] ch, input logic eof);
      int gap;
      if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
      gap = send_quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = ch;
      req_tlast  = eof;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent_items++;
   endtask

   task automatic send_pair(input logic [7:0] b, input logic [7:0] sep,
                            input logic [7:0] opt, input bit lower);
      send_char(hex_char(b[7:4], lower), 1'b0);
      send_char(hex_char(b[3:0], lower), 1'b0);
      send_char(sep, 1'b0);
      if (opt != NoChar) send_char(opt, 1'b0);
      sent_sum = sent_sum + {8'd0, b};
   endtask

   task automatic send_command(input logic [7:0] letter, input logic [35:0] value,
                               input int digits, input logic [7:0] term);
      send_char(CharDollar, 1'b0);
      send_char(letter, 1'b0);
      for (int i = digits - 1; i >= 0; i--)
         send_char(hex_char(value[4*i +: 4], 1'($urandom)), 1'b0);
      if (term != NoChar) send_char(term, 1'b0);
   endtask

   task automatic write_sum_check(input logic v);
      csr_data  = v;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic settle(input int cycles);
      req_tvalid = 1'b0;
      wait (pending_results == 0);
      repeat (cycles) @(negedge clock);
   endtask

   // well-formed body content only; nothing here ends the load
   task automatic random_token();
      int pick;
      logic [15:0] claimed;
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
         send_pair(8'($urandom), pick_sep(), pick_opt(), 1'($urandom));
      end else if (pick < 16) begin
         send_char(pick_blank(), 1'b0);
      end else if (pick < 18) begin
         send_command(CharUpA, {4'($urandom), 32'($urandom)}, $urandom_range(1, 9),
                      pick_term());
      end else begin
         claimed = (check_on || $urandom_range(0, 1)) ? sent_sum : 16'($urandom);
         send_command(CharUpS, {20'($urandom), claimed}, $urandom_range(4, 9), pick_term());
      end
   endtask

   // after the load has ended these are all dropped
   task automatic send_trailing();
      repeat (16) send_char(8'($urandom), 1'($urandom));
   endtask

   task automatic send_ending();
      load_end_type how;
      int digits;
      how = load_end_type'($urandom_range(0, 11));
      case (how)
         END_ETX: send_char(CharEtx, 1'b0);
         END_EOF_BODY: begin
            send_char(pick_blank(), 1'b0);
            send_char(8'($urandom), 1'b1);
         end
         END_EOF_AFTER_PAIR: begin
            send_char(hex_char(4'($urandom), 1'($urandom)), 1'b0);
            send_char(hex_char(4'($urandom), 1'($urandom)), 1'b0);
            send_char(8'($urandom), 1'b1);
            // end of load is reported on the next transfer, whatever it holds
            send_char(8'($urandom), 1'($urandom));
         end
         END_EOF_IN_PAIR: begin
            send_char(hex_char(4'($urandom), 1'($urandom)), 1'b0);
            send_char(8'($urandom), 1'b1);
         end
         END_EOF_AFTER_DOLLAR: begin
            send_char(CharDollar, 1'b0);
            send_char(8'($urandom), 1'b1);
         end
         END_EOF_IN_CMD: begin
            send_command(CharUpA, 36'($urandom), $urandom_range(0, 3), NoChar);
            send_char(8'($urandom), 1'b1);
         end
         END_ILLEGAL: begin
            case ($urandom_range(0, 3))
               0: send_char(CharVt, 1'b0);
               1: send_char(CharComma, 1'b0);
               2: send_char(CharStx, 1'b0);
               default: send_char(8'($urandom_range(128, 255)), 1'b0);
            endcase
         end
         END_BAD_PAIR_HEX: begin
            send_char(hex_char(4'($urandom), 1'($urandom)), 1'b0);
            send_char(pick_sep(), 1'b0);
         end
         END_BAD_CMD_HEX: begin
            digits = $urandom_range(0, 2);
            send_command(CharUpA, 36'($urandom), digits,
                         (digits == 0) ? pick_term() : CharDollar);
         end
         END_NO_SEP: begin
            send_char(hex_char(4'($urandom), 1'($urandom)), 1'b0);
            send_char(hex_char(4'($urandom), 1'($urandom)), 1'b0);
            send_char($urandom_range(0, 1) ? hex_char(4'($urandom), 1'b0) : CharComma, 1'b0);
         end
         END_UNKNOWN_CMD: begin
            send_command($urandom_range(0, 1) ? CharUpF : CharLowA, 36'($urandom),
                         $urandom_range(1, 4), pick_term());
         end
         default: begin
            // wrong sum; only fatal while checking is on
            send_command(CharUpS, {20'd0, sent_sum + 16'd1}, 4, CharComma);
            send_char(CharEtx, 1'b0);
         end
      endcase
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset = 1'b0;
      check_on = 1'($urandom);
      write_sum_check(check_on);
      if ($urandom_range(0, 11) == 0) begin
         // body without a single data pair
         send_char(8'($urandom), 1'b0);
         send_char(CharStx, 1'b0);
         send_char(pick_blank(), 1'b0);
         send_command(CharUpA, 36'($urandom), 8, CharDot);
         send_command(CharUpS, '0, 4, CharComma);
         if ($urandom_range(0, 1)) send_char(CharEtx, 1'b0);
         else send_char(8'($urandom), 1'b1);
      end else begin
         send_char(8'h00, 1'b0);
         send_char(8'hFF, 1'b0);
         send_char(CharEtx, 1'b0);
         send_char(CharStx, 1'b0);
         send_pair(8'h00, CharVt, CharQuote, 1'b0);
         send_pair(8'hFF, CharTab, CharPct, 1'b1);
         send_pair(8'hA5, CharFf, CharComma, 1'b0);
         // top address for the next pair, so the address after that pair wraps to zero
         send_command(CharUpA, 36'hFFFFFFFF, 8, CharComma);
         send_pair(8'h12, CharCr, CharSpace, 1'b1);
         for (int p = 0; p < 3; p++) begin
            if (p > 0) begin
               settle(4);
               check_on = !check_on;
               write_sum_check(check_on);
            end
            while (sent_items < OpeningItems + (p + 1) * PhaseItems) random_token();
         end
         send_ending();
      end
      send_trailing();
      settle(10);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin : take_results
      int waits;
      wait (!reset);
      forever begin
         if ($urandom_range(0, 29) == 0) recv_quiet = !recv_quiet;
         waits = recv_quiet ? 0 : $urandom_range(0, 3);
         if (waits > 0) begin
            want_ready = 1'b0;
            repeat (waits) @(negedge clock);
         end
         want_ready = 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   // long back-pressure while characters keep coming
   initial begin
      wait (sent_items >= 120);
      @(negedge clock);
      stall_hold = 1'b1;
      repeat (HoldCycles) @(negedge clock);
      stall_hold = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= RunLimit);
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ahlp_pkg.sv
rtl/ahlp_char_class.sv
rtl/ahlp_parse_core.sv
rtl/ascii_hex_load_parser.sv
bench/parse_result_monitor.sv
bench/tb.sv
